@@ hdl/tli_pkg.sv @@
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SMALL     = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_t;

  // Item passed from the front part to the back part.
  typedef struct packed {
    logic                      is_small;
    logic signed [VALUE_W-1:0] query;
  } job_t;

endpackage

@@ hdl/tli_if.sv @@
// ----------------------------------------------------------------------------
// tli_in_if / tli_out_if / tli_cfg_if
// Valid/ready channels of the table linear interpolator.
// ----------------------------------------------------------------------------
interface tli_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  func;
  logic [9:0]  entry_index;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  modport source(output valid, func, entry_index, x_value, y_value, input ready);
  modport sink(input valid, func, entry_index, x_value, y_value, output ready);
endinterface

interface tli_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] interp_value;
  logic [9:0]  bracket_index;
  logic [1:0]  status;
  modport source(output valid, interp_value, bracket_index, status, input ready);
  modport sink(input valid, interp_value, bracket_index, status, output ready);
endinterface

interface tli_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ hdl/tli_queue.sv @@
// ----------------------------------------------------------------------------
// tli_queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module tli_queue
  import tli_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rptr_r];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hdl/tli_divider.sv @@
// ----------------------------------------------------------------------------
// tli_divider
// Restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module tli_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] div_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [33:0] trial;

  assign trial = {rem_r[32:0], quo_r[63]};

  always_comb begin
    quo_nxt = {quo_r[62:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, div_r}) begin
      rem_nxt    = trial - {1'b0, div_r};
      quo_nxt[0] = 1'b1;
    end
  end

  assign quotient = quo_r;
  assign done = busy_r && (cnt_r == 7'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
      quo_r  <= dividend;
      rem_r  <= 34'd0;
      div_r  <= divisor;
    end else if (busy_r) begin
      if (cnt_r == 7'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 7'd1;
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

endmodule

@@ hdl/tli_front.sv @@
// ----------------------------------------------------------------------------
// tli_front
// Accepts items: performs table writes and queues queries for the back part.
// ----------------------------------------------------------------------------
module tli_front
  import tli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ADDR_W = 10
) (
  tli_in_if.sink            in_ch,
  input  logic [COUNT_W-1:0] count_eff,
  input  logic              query_busy,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [VALUE_W-1:0] wr_x,
  output logic [VALUE_W-1:0] wr_y,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job_data
);

  logic accept;

  // A write waits until no query is pending, so every query sees the table
  // as it stood when the query was accepted. Queries wait for queue room.
  assign in_ch.ready = (in_ch.func == FUNC_WRITE) ? !query_busy : job_ready;
  assign accept = in_ch.valid && in_ch.ready;

  // Indexes beyond the table are dropped.
  assign wr_en = accept && (in_ch.func == FUNC_WRITE) &&
                 (32'(in_ch.entry_index) < TABLE_DEPTH);
  assign wr_addr = ADDR_W'(in_ch.entry_index);
  assign wr_x = in_ch.x_value;
  assign wr_y = in_ch.y_value;

  assign job_valid = in_ch.valid && (in_ch.func == FUNC_QUERY);
  assign job_data.is_small = (count_eff < COUNT_W'(2));
  assign job_data.query = in_ch.x_value;

endmodule

@@ hdl/tli_back.sv @@
// ----------------------------------------------------------------------------
// tli_back
// Bisects the table, reads the bracket and evaluates the segment.
// ----------------------------------------------------------------------------
module tli_back
  import tli_pkg::*;
#(
  parameter int unsigned ADDR_W = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  job_t               job_data,
  input  logic [ADDR_W:0]    n_in,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [VALUE_W-1:0] wr_x,
  input  logic [VALUE_W-1:0] wr_y,
  output logic               busy,
  tli_out_if.source          out_ch
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_END0  = 11'b00000000010,
    S_END1  = 11'b00000000100,
    S_BIS   = 11'b00000001000,
    S_BISW  = 11'b00000010000,
    S_RD0   = 11'b00000100000,
    S_RD1   = 11'b00001000000,
    S_MUL   = 11'b00010000000,
    S_START = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  logic [VALUE_W-1:0] xmem [1 << ADDR_W];
  logic [VALUE_W-1:0] ymem [1 << ADDR_W];
  logic [VALUE_W-1:0] xrd_r, yrd_r;
  logic [ADDR_W-1:0]  raddr;

  state_t state_r, state_nxt;
  logic signed [31:0] q_r, x0_r, y0_r, xf_r;
  logic [ADDR_W:0]    jl_r, ju_r, jm;
  logic               asc_r;
  logic [31:0]        dxm_r, dym_r;
  logic [32:0]        denm_r;
  logic               neg_r, eq_r;
  logic [63:0]        prod;
  logic               div_start;
  logic               div_done;
  logic [63:0]        quo;
  logic               ov_r;
  logic signed [31:0] res_r;
  logic signed [31:0] val_r;
  logic [ADDR_W-1:0]  j_r;
  logic [1:0]         st_r;
  logic               ovalid_r;
  logic               out_load;
  logic signed [32:0] dx, dy, den;
  logic signed [35:0] sum;

  assign jm = (ADDR_W + 1)'(({1'b0, jl_r} + {1'b0, ju_r}) >> 1);

  always_comb begin
    unique case (state_r)
      S_END0: raddr = '0;
      S_END1: raddr = ADDR_W'(n_in - 1'b1);
      S_BIS:  raddr = jm[ADDR_W-1:0];
      S_RD0:  raddr = jl_r[ADDR_W-1:0];
      S_RD1:  raddr = ADDR_W'(jl_r + 1'b1);
      default: raddr = jl_r[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      xmem[wr_addr] <= wr_x;
      ymem[wr_addr] <= wr_y;
    end
    xrd_r <= xmem[raddr];
    yrd_r <= ymem[raddr];
  end

  // The magnitudes fit 32 bits, so the product is a 32-by-32 multiply.
  assign prod = 64'(dxm_r) * 64'(dym_r);

  tli_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (denm_r),
    .done     (div_done),
    .quotient (quo)
  );

  // A small-table request is answered at once, so it waits for a free output.
  assign job_ready = (state_r == S_IDLE) &&
                     (!job_data.is_small || !ovalid_r || out_ch.ready);
  assign busy = (state_r != S_IDLE);
  assign div_start = (state_r == S_START) && !eq_r;
  assign out_load = ((state_r == S_IDLE) && job_valid && job_ready && job_data.is_small) ||
                    ((state_r == S_OUT) && (!ovalid_r || out_ch.ready));
  assign out_ch.valid = ovalid_r;
  assign out_ch.interp_value = val_r;
  assign out_ch.bracket_index = INDEX_W'(j_r);
  assign out_ch.status = st_r;

  assign dx  = 33'(q_r) - 33'(x0_r);
  assign dy  = 33'($signed(yrd_r)) - 33'(y0_r);
  assign den = 33'($signed(xrd_r)) - 33'(x0_r);
  assign sum = 36'(y0_r) + (neg_r ? -$signed({1'b0, quo[34:0]}) :
                                      $signed({1'b0, quo[34:0]}));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (job_valid && job_ready && !job_data.is_small) state_nxt = S_END0;
      S_END0: state_nxt = S_END1;
      S_END1: state_nxt = S_BIS;
      S_BIS:  state_nxt = (ju_r - jl_r > 1) ? S_BISW : S_RD0;
      S_BISW: state_nxt = S_BIS;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_START;
      S_START: state_nxt = eq_r ? S_OUT : S_DIV;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (!ovalid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          q_r <= job_data.query;
          if (out_load) begin
            val_r <= '0;
            j_r   <= '0;
            st_r  <= STATUS_SMALL;
          end
        end
        S_END0: begin
          jl_r <= '0;
          ju_r <= n_in - 1'b1;
        end
        S_END1: xf_r <= $signed(xrd_r);
        S_BIS: begin
          // Last-entry read arrives now; the first iteration fixes direction.
          if (ju_r == n_in - 1'b1 && jl_r == '0) asc_r <= $signed(xrd_r) >= xf_r;
        end
        S_BISW: begin
          if ((q_r >= $signed(xrd_r)) == asc_r) jl_r <= jm;
          else ju_r <= jm;
        end
        S_RD0: ;
        S_RD1: begin
          x0_r <= $signed(xrd_r);
          y0_r <= $signed(yrd_r);
        end
        S_MUL: begin
          eq_r   <= ($signed(xrd_r) == x0_r);
          dxm_r  <= dx[32] ? 32'(-dx) : 32'(dx);
          dym_r  <= dy[32] ? 32'(-dy) : 32'(dy);
          denm_r <= den[32] ? 33'(-den) : 33'(den);
          neg_r  <= (dx[32] != dy[32]) != den[32];
        end
        S_START: ;
        S_DIV: begin
          if (div_done) begin
            if (quo > 64'h4_0000_0000) begin
              ov_r <= 1'b1;
              res_r <= neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else if (sum > 36'sd2147483647) begin
              ov_r <= 1'b1;
              res_r <= 32'sh7fff_ffff;
            end else if (sum < -36'sd2147483648) begin
              ov_r <= 1'b1;
              res_r <= 32'sh8000_0000;
            end else begin
              ov_r <= 1'b0;
              res_r <= 32'(sum);
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            j_r <= jl_r[ADDR_W-1:0];
            val_r <= eq_r ? y0_r : res_r;
            st_r <= (!eq_r && ov_r) ? STATUS_SATURATED : STATUS_OK;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/table_linear_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator_unit
// Piecewise-linear interpolation over a written table of Q16.16 points.
// ----------------------------------------------------------------------------
// A write request stores one (x, y) point. A query runs in the back part: two
// end reads, bisection steps of a probe state and an update state (ten steps
// for a full table), two bracket reads, a magnitude stage, a divider start,
// then a 64-by-33 restoring divider at one quotient bit per cycle. A bracket
// with equal abscissas skips the divider, and a table that is too small is
// answered straight from the idle state. A two-entry queue holds queries while
// the back part is busy. A write waits until no query is pending, so each query
// sees the table as it stood when it was accepted.
module table_linear_interpolator_unit
  import tli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  tli_in_if.sink    in_ch,
  tli_out_if.source out_ch,
  tli_cfg_if.sink   cfg_ch
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  logic [COUNT_W-1:0] count_r;
  logic [ADDR_W:0]    n_eff;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VALUE_W-1:0] wr_x, wr_y;
  logic               fq_valid, fq_ready, bq_valid, bq_ready;
  logic               back_busy, query_busy;
  job_t               fq_data, bq_data;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cfg_ch.valid) count_r <= cfg_ch.data;
  end

  assign n_eff = (32'(count_r) > TABLE_DEPTH) ? (ADDR_W + 1)'(TABLE_DEPTH)
                                               : (ADDR_W + 1)'(count_r);

  assign query_busy = bq_valid || back_busy;

  tli_front #(.TABLE_DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_front (
    .in_ch,
    .count_eff (COUNT_W'(n_eff)),
    .query_busy,
    .wr_en, .wr_addr, .wr_x, .wr_y,
    .job_valid (fq_valid), .job_ready (fq_ready), .job_data (fq_data)
  );

  tli_queue u_queue (
    .clk, .rst_n,
    .push_valid (fq_valid), .push_ready (fq_ready), .push_data (fq_data),
    .pop_valid (bq_valid), .pop_ready (bq_ready), .pop_data (bq_data)
  );

  tli_back #(.ADDR_W(ADDR_W)) u_back (
    .clk, .rst_n,
    .job_valid (bq_valid), .job_ready (bq_ready), .job_data (bq_data),
    .n_in (n_eff),
    .wr_en, .wr_addr, .wr_x, .wr_y,
    .busy (back_busy),
    .out_ch
  );

endmodule

@@ hdl/tli_checker.sv @@
// ----------------------------------------------------------------------------
// tli_checker
// Port-level checks of the table linear interpolator.
// ----------------------------------------------------------------------------
module tli_checker
  import tli_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_interp_value,
  input logic [1:0]  out_status,
  input logic [9:0]  out_bracket_index
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interp_value))
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status");

  a_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_SMALL |-> out_interp_value == 32'd0 &&
    out_bracket_index == 10'd0)
    else $error("small table result not zero");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_SATURATED |->
    out_interp_value == 32'h7fff_ffff || out_interp_value == 32'h8000_0000)
    else $error("saturated result not at a limit");

endmodule

bind table_linear_interpolator_unit tli_checker u_tli_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_interp_value  (out_ch.interp_value),
  .out_status        (out_ch.status),
  .out_bracket_index (out_ch.bracket_index)
);

@@ tb/table_linear_interpolator_unit_test.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator_unit_test
// Fills the point table, sets the entry count and sends interpolation
// requests. Every result is checked against a local predictor of the
// bisection, extrapolation and saturation rules, under several idle and
// stall mixes on both channels.
// ----------------------------------------------------------------------------
module table_linear_interpolator_unit_test;
  import tli_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    logic signed [31:0] value;
    logic [9:0]         bracket;
    status_t            status;
  } interp_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tli_in_if  in_ch();
  tli_out_if out_ch();
  tli_cfg_if cfg_ch();

  table_linear_interpolator_unit #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic signed [31:0] abscissa_mem[DEPTH];
  logic signed [31:0] ordinate_mem[DEPTH];
  logic [10:0] entry_count;
  interp_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic interp_result_t interpolate_point(logic signed [31:0] q);
    interp_result_t r;
    int unsigned n, lo, hi, mid;
    logic asc, neg;
    longint x0, x1, y0, y1, dx, dy, den, val;
    longint unsigned adx, ady, aden, mag;
    r.value = '0;
    r.bracket = '0;
    r.status = STATUS_OK;
    n = (entry_count > DEPTH) ? DEPTH : entry_count;
    if (n < 2) begin
      r.status = STATUS_SMALL;
      return r;
    end
    asc = abscissa_mem[n-1] >= abscissa_mem[0];
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (hi + lo) >> 1;
      if ((q >= abscissa_mem[mid]) == asc) lo = mid;
      else hi = mid;
    end
    x0 = abscissa_mem[lo];
    x1 = abscissa_mem[lo+1];
    y0 = ordinate_mem[lo];
    y1 = ordinate_mem[lo+1];
    r.bracket = lo[9:0];
    if (x0 == x1) begin
      val = y0;
    end else begin
      dx = longint'(q) - x0;
      dy = y1 - y0;
      den = x1 - x0;
      neg = ((dx < 0) != (dy < 0)) != (den < 0);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      aden = (den < 0) ? -den : den;
      mag = (adx * ady) / aden;
      if (mag > 64'h4_0000_0000) begin
        val = neg ? -64'sd2147483648 : 64'sd2147483647;
        r.status = STATUS_SATURATED;
      end else begin
        val = y0 + (neg ? -longint'(mag) : longint'(mag));
        if (val > 64'sd2147483647) begin
          val = 64'sd2147483647;
          r.status = STATUS_SATURATED;
        end else if (val < -64'sd2147483648) begin
          val = -64'sd2147483648;
          r.status = STATUS_SATURATED;
        end
      end
    end
    r.value = val[31:0];
    return r;
  endfunction

  // Waits until every expected result has come back, then lets the block settle.
  task automatic drain_results(int unsigned tail);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic send_request(func_t f, logic [9:0] idx, logic signed [31:0] xv,
                              logic signed [31:0] yv);
    // A queued query reads the table late, so writes wait for it to finish.
    if (f == FUNC_WRITE && pending_results.size() != 0) drain_results(0);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.entry_index <= idx;
    in_ch.x_value <= xv;
    in_ch.y_value <= yv;
    do @(posedge clk); while (!in_ch.ready);
    if (f == FUNC_WRITE) begin
      abscissa_mem[idx] = xv;
      ordinate_mem[idx] = yv;
    end else begin
      pending_results.push_back(interpolate_point(xv));
    end
  endtask

  task automatic query(logic signed [31:0] q);
    send_request(FUNC_QUERY, 10'($urandom), q, $urandom);
  endtask

  task automatic set_entry_count(logic [10:0] count);
    drain_results(SETTLE_CYCLES);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= count;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    entry_count = count;
  endtask

  task automatic test_small_table();
    set_entry_count(11'd0);
    query(32'sh7fffffff);
    query(32'sh80000000);
    set_entry_count(11'd1);
    query(32'sd0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < DEPTH; i++)
      send_request(FUNC_WRITE, 10'(i), (i - 512) <<< 16, $urandom);
    set_entry_count(11'd1024);
    query(32'sh80000000);
    query(32'sh7fffffff);
    query(32'sd0);
    query(32'sh0001_8000);
    query(-32'sh0200_0000);
    set_entry_count(11'd2047);
    query(32'sh0100_4000);
    set_entry_count(11'd1023);
    query(32'sh7fffffff);
  endtask

  task automatic test_equal_abscissa();
    send_request(FUNC_WRITE, 10'd0, 32'sh0003_0000, 32'sh0000_1234);
    send_request(FUNC_WRITE, 10'd1, 32'sh0003_0000, -32'sh0005_0000);
    set_entry_count(11'd2);
    query(32'sh0003_0000);
    query(32'sh7fffffff);
  endtask

  task automatic test_saturation();
    send_request(FUNC_WRITE, 10'd0, 32'sd0, 32'sh80000000);
    send_request(FUNC_WRITE, 10'd1, 32'sd1, 32'sh7fffffff);
    set_entry_count(11'd2);
    query(32'sh7fffffff);
    query(32'sh80000000);
    query(32'sd1);
    query(32'sd2);
  endtask

  task automatic test_descending();
    send_request(FUNC_WRITE, 10'd0, 32'sh0004_0000, 32'sh0001_0000);
    send_request(FUNC_WRITE, 10'd1, 32'sh0000_0000, 32'sh0002_0000);
    send_request(FUNC_WRITE, 10'd2, -32'sh0004_0000, -32'sh0001_0000);
    set_entry_count(11'd3);
    query(32'sh0002_0000);
    query(-32'sh0006_0000);
  endtask

  // One round: a fresh table of random shape, then a burst of queries.
  task automatic run_random_round();
    int unsigned n, shape, nq;
    logic signed [31:0] xs[$];
    logic signed [31:0] q;
    logic wide;
    n = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(16, 2);
    shape = $urandom_range(7);
    wide = 1'($urandom_range(1));
    xs.delete();
    for (int i = 0; i < n; i++)
      xs.push_back(wide ? 32'($urandom) : 32'($urandom_range(2 ** 21) - 2 ** 20));
    if (shape != 0) xs.sort();
    if (shape >= 5) xs.reverse();
    if (n > 2 && $urandom_range(3) == 0) begin
      int unsigned k;
      k = $urandom_range(n - 1, 1);
      xs[k] = xs[k-1];
    end
    for (int i = 0; i < n; i++)
      send_request(FUNC_WRITE, 10'(i), xs[i],
                   wide ? 32'($urandom) : 32'($urandom_range(2 ** 22) - 2 ** 21));
    set_entry_count(11'(n));
    nq = $urandom_range(14, 4);
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(4))
        0: q = $urandom;
        1: q = (n > 0) ? xs[$urandom_range(n - 1)] : 32'($urandom);
        2: q = (n > 0) ? xs[$urandom_range(n - 1)] + 32'($urandom_range(64) - 32)
                       : 32'($urandom);
        3: q = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        default: q = 32'($urandom_range(2 ** 23) - 2 ** 22);
      endcase
      query(q);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int r = 0; r < 5; r++) run_random_round();
    end
  endtask

  always @(posedge clk) begin
    interp_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: value %0d", out_ch.interp_value);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.interp_value !== want.value) begin
            $error("interp_value: expected %0d, got %0d", want.value, out_ch.interp_value);
            error_count++;
          end
          if (out_ch.bracket_index !== want.bracket) begin
            $error("bracket_index: expected %0d, got %0d", want.bracket,
                   out_ch.bracket_index);
            error_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            error_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("table_linear_interpolator_unit_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_WRITE;
    in_ch.entry_index <= '0;
    in_ch.x_value <= '0;
    in_ch.y_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    entry_count = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_table();
    test_full_table();
    test_equal_abscissa();
    test_saturation();
    test_descending();
    test_random_traffic();
    drain_results(100);
    if (error_count == 0) begin
      $display("table_linear_interpolator_unit_test: done, clean");
    end else begin
      $display("table_linear_interpolator_unit_test: done, errors");
    end
    $finish;
  end

endmodule
